// ----- design/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache tag model.
// No dependencies; every other design file but salc_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int ADDR_W     = 32;
  localparam int BSL_W      = 4;
  localparam int BSL_MIN    = 2;
  localparam int BSL_MAX    = 12;
  localparam int BSL_RESET  = 6;
  localparam int WAY_OUT_W  = 2;
  localparam int SET_OUT_W  = 7;
  localparam int COUNT_W    = 64;

  localparam int LINES_DEFAULT = 512;
  localparam int WAYS_DEFAULT  = 4;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic CFG_IDX_BSL = 1'b0;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic div_en;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- design/salc_if.sv -----
// Request and response channel interfaces for the cache tag model.
// Depends on salc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface salc_req_if;
  import salc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              opcode;

  modport source (output valid, output address, output opcode, input ready);
  modport sink   (input valid, input address, input opcode, output ready);
endinterface

interface salc_rsp_if;
  import salc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic [SET_OUT_W-1:0] set_index;
  logic [COUNT_W-1:0]   read_count;
  logic [COUNT_W-1:0]   read_hit_count;
  logic [COUNT_W-1:0]   write_count;
  logic [COUNT_W-1:0]   write_hit_count;

  modport source (output valid, output hit, output way, output set_index,
                  output read_count, output read_hit_count, output write_count,
                  output write_hit_count, input ready);
  modport sink   (input valid, input hit, input way, input set_index,
                  input read_count, input read_hit_count, input write_count,
                  input write_hit_count, output ready);
endinterface

`default_nettype wire

// ----- design/salc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/salc_ctrl.sv -----
// Sequencing state machine: clearing pass, request intake, lookup steps, commit.
// Depends on salc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module salc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output salc_pkg::ctrl_cmd_t      cmd,
  input  wire salc_pkg::ctrl_sts_t sts
);
  import salc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        // hold the looked-up row until the result slot frees up
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/salc_dp.sv -----
// Datapath: config register, address split, tag/LRU memories, lookup, counters.
// Depends on salc_pkg, salc_ram.
`timescale 1ns / 1ps
`default_nettype none

module salc_dp #(
  parameter int LINES = salc_pkg::LINES_DEFAULT,
  parameter int WAYS  = salc_pkg::WAYS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [salc_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [salc_pkg::PDATA_W-1:0]       pwdata,
  output logic      [salc_pkg::PDATA_W-1:0]       prdata,
  // request payload
  input  wire logic [salc_pkg::ADDR_W-1:0]        address,
  input  wire logic                               opcode,
  // response payload
  output logic                                    hit,
  output logic      [salc_pkg::WAY_OUT_W-1:0]     way,
  output logic      [salc_pkg::SET_OUT_W-1:0]     set_index,
  output logic      [salc_pkg::COUNT_W-1:0]       read_count,
  output logic      [salc_pkg::COUNT_W-1:0]       read_hit_count,
  output logic      [salc_pkg::COUNT_W-1:0]       write_count,
  output logic      [salc_pkg::COUNT_W-1:0]       write_hit_count,
  input  wire salc_pkg::ctrl_cmd_t                cmd,
  output salc_pkg::ctrl_sts_t                     sts
);
  import salc_pkg::*;

  localparam int SETS_RAW = LINES / WAYS;
  localparam int SETS     = (SETS_RAW == 0) ? 1 : SETS_RAW;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BLK_W    = ADDR_W - BSL_MIN;
  localparam int TAG_W    = BLK_W - ($clog2(SETS + 1) - 1);

  // quotient by the set count through a reciprocal multiply (exact for BLK_W bits)
  localparam int DIV_L    = $clog2(SETS);
  localparam int DIV_S    = BLK_W + DIV_L;
  localparam int RECIP_W  = BLK_W + 1;
  localparam int PROD_W   = BLK_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_S) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  localparam int TAG_ROW_W = WAYS * TAG_W;
  localparam int ST_ROW_W  = WAYS * (1 + WAY_W);

  // configuration register
  logic [BSL_W-1:0] bsl;
  logic [BSL_W-1:0] bsl_eff;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == CFG_IDX_BSL);

  always_ff @(posedge clk) begin
    if (rst) begin
      bsl <= BSL_W'(BSL_RESET);
    end else if (cfg_wr) begin
      bsl <= pwdata[BSL_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1:2] == CFG_IDX_BSL) ? PDATA_W'(bsl) : '0;

  always_comb begin
    bsl_eff = bsl;
    if (bsl < BSL_W'(BSL_MIN)) begin
      bsl_eff = BSL_W'(BSL_MIN);
    end else if (bsl > BSL_W'(BSL_MAX)) begin
      bsl_eff = BSL_W'(BSL_MAX);
    end
  end

  // request capture and address split
  logic [ADDR_W-1:0] addr_sh;
  logic [BLK_W-1:0]  blk_q;
  logic              op_q;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [BLK_W-1:0]  quo_q;
  logic [BLK_W-1:0]  rem_full;
  logic [SET_W-1:0]  set_cur;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  cur_tag;

  assign addr_sh  = address >> bsl_eff;
  assign prod     = PROD_W'(blk_q) * PROD_W'(RECIP);
  assign prod_sh  = prod >> DIV_S;
  assign rem_full = blk_q - BLK_W'(quo_q * BLK_W'(SETS));
  assign set_cur  = rem_full[SET_W-1:0];
  assign cur_tag  = quo_q[TAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      blk_q <= addr_sh[BLK_W-1:0];
      op_q  <= opcode;
    end
    if (cmd.div_en) begin
      quo_q <= prod_sh[BLK_W-1:0];
    end
    if (cmd.rd_en) begin
      set_q <= set_cur;
    end
  end

  // clearing pass over the valid/LRU rows
  logic [SET_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign sts.clear_done = (clr_idx == SET_W'(SETS - 1));

  // memories
  logic [TAG_ROW_W-1:0] tag_row;
  logic [TAG_ROW_W-1:0] tag_new;
  logic [ST_ROW_W-1:0]  st_row;
  logic [ST_ROW_W-1:0]  st_new;
  logic [ST_ROW_W-1:0]  st_init;
  logic [ST_ROW_W-1:0]  st_wdata;
  logic [SET_W-1:0]     st_waddr;

  salc_ram #(.WIDTH(TAG_ROW_W), .DEPTH(SETS), .AW(SET_W)) u_tag_ram (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (set_q),
    .wr_data (tag_new),
    .rd_en   (cmd.rd_en),
    .rd_addr (set_cur),
    .rd_data (tag_row)
  );

  assign st_waddr = cmd.clear_wr ? clr_idx : set_q;
  assign st_wdata = cmd.clear_wr ? st_init : st_new;

  salc_ram #(.WIDTH(ST_ROW_W), .DEPTH(SETS), .AW(SET_W)) u_st_ram (
    .clk     (clk),
    .wr_en   (cmd.clear_wr || cmd.commit),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (set_cur),
    .rd_data (st_row)
  );

  // lookup and LRU update
  logic [WAYS-1:0]        row_valid;
  logic [WAY_W-1:0]       row_lru [WAYS];
  logic [TAG_W-1:0]       row_tag [WAYS];
  logic                   hit_found;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       victim;
  logic [WAY_W-1:0]       sel_way;
  logic [WAY_W-1:0]       pos;
  logic                   pos_found;
  logic [WAYS*WAY_W-1:0]  lru_new;
  logic [WAYS*WAY_W-1:0]  lru_init;
  logic [WAYS-1:0]        valid_new;

  assign row_valid = st_row[WAYS-1:0];

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      row_lru[i]  = st_row[WAYS + i*WAY_W +: WAY_W];
      row_tag[i]  = tag_row[i*TAG_W +: TAG_W];
      lru_init[i*WAY_W +: WAY_W] = WAY_W'(i);
    end
  end

  assign st_init = {lru_init, {WAYS{1'b0}}};

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit_found && row_valid[i] && (row_tag[i] == cur_tag)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
    end
  end

  always_comb begin
    victim = row_lru[0];
    if ({1'b0, victim} >= (WAY_W + 1)'(WAYS)) begin
      victim = '0;
    end
  end

  assign sel_way = hit_found ? hit_way : victim;

  always_comb begin
    pos_found = 1'b0;
    pos       = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!pos_found && (row_lru[i] == sel_way)) begin
        pos_found = 1'b1;
        pos       = WAY_W'(i);
      end
    end
  end

  // shift the later entries down one place and put the touched way last
  always_comb begin
    for (int i = 0; i < WAYS - 1; i++) begin
      lru_new[i*WAY_W +: WAY_W] = (i >= int'(pos)) ? row_lru[i+1] : row_lru[i];
    end
    lru_new[(WAYS-1)*WAY_W +: WAY_W] = sel_way;
  end

  always_comb begin
    valid_new = row_valid;
    tag_new   = tag_row;
    for (int i = 0; i < WAYS; i++) begin
      if (sel_way == WAY_W'(i)) begin
        valid_new[i]              = 1'b1;
        tag_new[i*TAG_W +: TAG_W] = cur_tag;
      end
    end
  end

  assign st_new = {lru_new, valid_new};

  // counters and result register; counters only move on commit, when the
  // previous result has been taken, so they double as the result fields
  logic [31:0] way_ext;
  logic [31:0] set_ext;

  assign way_ext = 32'(sel_way);
  assign set_ext = 32'(set_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      read_count      <= '0;
      read_hit_count  <= '0;
      write_count     <= '0;
      write_hit_count <= '0;
    end else if (cmd.commit) begin
      if (op_q == OP_WRITE) begin
        write_count <= write_count + 1'b1;
        if (hit_found) begin
          write_hit_count <= write_hit_count + 1'b1;
        end
      end else begin
        read_count <= read_count + 1'b1;
        if (hit_found) begin
          read_hit_count <= read_hit_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit       <= hit_found;
      way       <= way_ext[WAY_OUT_W-1:0];
      set_index <= set_ext[SET_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/set_assoc_lru_cache_model.sv -----
// Each request passes through capture, divide, memory read, and compare and
// write-back of the tag and LRU rows; a new request is taken only once the last
// one has committed, and commit waits until the result slot is free.
// Reset: a clearing pass over the LINES/WAYS valid/LRU rows (128 by default)
// with ready low; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_model #(
  parameter int LINES = salc_pkg::LINES_DEFAULT,
  parameter int WAYS  = salc_pkg::WAYS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [salc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [salc_pkg::PDATA_W-1:0] pwdata,
  output logic      [salc_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  salc_req_if.sink                          req,
  salc_rsp_if.source                        rsp
);
  import salc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign pready = 1'b1;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  salc_dp #(.LINES(LINES), .WAYS(WAYS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .address         (req.address),
    .opcode          (req.opcode),
    .hit             (rsp.hit),
    .way             (rsp.way),
    .set_index       (rsp.set_index),
    .read_count      (rsp.read_count),
    .read_hit_count  (rsp.read_hit_count),
    .write_count     (rsp.write_count),
    .write_hit_count (rsp.write_hit_count),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

// ----- design/salc_checker.sv -----
// Port-level checks for the cache tag model, attached to the top level by bind.
// Depends on salc_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module salc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_hit,
  input wire logic [salc_pkg::WAY_OUT_W-1:0] out_way,
  input wire logic [salc_pkg::SET_OUT_W-1:0] out_set_index,
  input wire logic                         psel,
  input wire logic                         pwrite,
  input wire logic [salc_pkg::PADDR_W-1:0] paddr,
  input wire logic [salc_pkg::PDATA_W-1:0] prdata
);
  import salc_pkg::*;

  logic in_accept;
  assign in_accept = in_valid && in_ready;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_hit) && $stable(out_way) && $stable(out_set_index)))
    else $error("stalled response changed");

  // requests are never accepted back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("request accepted on consecutive cycles");

  // a new result never rises while an accepted request is in its divide or read step
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (!$past(in_accept, 1) && !$past(in_accept, 2)))
    else $error("result appeared too early");

  // block size register reads back in its low bits only
  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    (psel && !pwrite && (paddr[PADDR_W-1:2] == CFG_IDX_BSL)) |->
      (prdata[PDATA_W-1:BSL_W] == '0))
    else $error("config readback has stray upper bits");

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .out_hit       (rsp.hit),
  .out_way       (rsp.way),
  .out_set_index (rsp.set_index),
  .psel          (psel),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .prdata        (prdata)
);

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the set-associative LRU cache tag model: directed and random accesses
// checked against a built-in tag/LRU predictor and its hit and access counters.
// Depends on salc_pkg, the request/response interfaces and the design top level.
`timescale 1ns / 1ps

module testbench;
  import salc_pkg::*;

  localparam int SETS     = LINES_DEFAULT / WAYS_DEFAULT;
  localparam int SET_BITS = $clog2(SETS);

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [SET_OUT_W-1:0] set_index;
    logic [COUNT_W-1:0]   read_count;
    logic [COUNT_W-1:0]   read_hit_count;
    logic [COUNT_W-1:0]   write_count;
    logic [COUNT_W-1:0]   write_hit_count;
  } lookup_t;

  class cache_scoreboard;
    logic [BSL_W-1:0]     block_size_log;
    bit                   line_valid [LINES_DEFAULT];
    logic [ADDR_W-1:0]    line_tag [LINES_DEFAULT];
    logic [WAY_OUT_W-1:0] lru_order [LINES_DEFAULT];
    logic [COUNT_W-1:0]   reads, read_hits, writes, write_hits;
    lookup_t              expected_lookups [$];
    int                   errors;

    function new();
      block_size_log = BSL_RESET;
      for (int i = 0; i < LINES_DEFAULT; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        lru_order[i]  = WAY_OUT_W'(i % WAYS_DEFAULT);
      end
      reads      = '0;
      read_hits  = '0;
      writes     = '0;
      write_hits = '0;
      errors     = 0;
    endfunction

    // clamp the configured block size into its meaningful range
    function int unsigned offset_bits();
      if (block_size_log < BSL_MIN) return BSL_MIN;
      if (block_size_log > BSL_MAX) return BSL_MAX;
      return block_size_log;
    endfunction

    function void note_access(logic [ADDR_W-1:0] address, logic opcode);
      lookup_t           want;
      logic [ADDR_W-1:0] blk, tag;
      int unsigned       set_no, base, w, pos;
      bit                hit;
      blk    = address >> offset_bits();
      set_no = blk % SETS;
      tag    = blk / SETS;
      base   = set_no * WAYS_DEFAULT;
      hit    = 1'b0;
      w      = 0;
      for (int i = 0; i < WAYS_DEFAULT; i++) begin
        if (!hit && line_valid[base + i] && line_tag[base + i] == tag) begin
          hit = 1'b1;
          w   = i;
        end
      end
      if (!hit) begin
        w = lru_order[base];
        line_valid[base + w] = 1'b1;
        line_tag[base + w]   = tag;
      end
      // move the way to the most recent end of the order
      pos = 0;
      for (int i = 0; i < WAYS_DEFAULT; i++)
        if (lru_order[base + i] == w) pos = i;
      for (int i = pos; i < WAYS_DEFAULT - 1; i++)
        lru_order[base + i] = lru_order[base + i + 1];
      lru_order[base + WAYS_DEFAULT - 1] = WAY_OUT_W'(w);
      if (opcode == OP_WRITE) begin
        writes++;
        if (hit) write_hits++;
      end else begin
        reads++;
        if (hit) read_hits++;
      end
      want.hit             = hit;
      want.way             = WAY_OUT_W'(w);
      want.set_index       = SET_OUT_W'(set_no);
      want.read_count      = reads;
      want.read_hit_count  = read_hits;
      want.write_count     = writes;
      want.write_hit_count = write_hits;
      expected_lookups.push_back(want);
    endfunction

    function void compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lookup_t got);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        $display("%0t: response with no request outstanding, expected none, actual hit %0h way %0h set %0h",
                 $time, got.hit, got.way, got.set_index);
        errors++;
        return;
      end
      want = expected_lookups.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("way", want.way, got.way);
      compare_field("set_index", want.set_index, got.set_index);
      compare_field("read_count", want.read_count, got.read_count);
      compare_field("read_hit_count", want.read_hit_count, got.read_hit_count);
      compare_field("write_count", want.write_count, got.write_count);
      compare_field("write_hit_count", want.write_hit_count, got.write_hit_count);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  bit                 steady;

  cache_scoreboard sb = new();

  salc_req_if req_ch ();
  salc_rsp_if rsp_ch ();

  set_assoc_lru_cache_model dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // response side back-pressure
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin : watch_responses
    lookup_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.hit             = rsp_ch.hit;
      got.way             = rsp_ch.way;
      got.set_index       = rsp_ch.set_index;
      got.read_count      = rsp_ch.read_count;
      got.read_hit_count  = rsp_ch.read_hit_count;
      got.write_count     = rsp_ch.write_count;
      got.write_hit_count = rsp_ch.write_hit_count;
      sb.check_result(got);
    end
  end

  function automatic logic [ADDR_W-1:0] block_address(int unsigned shift, int unsigned set_no,
                                                      logic [ADDR_W-1:0] tag,
                                                      logic [ADDR_W-1:0] offset);
    logic [ADDR_W-1:0] blk;
    blk = (tag << SET_BITS) | ADDR_W'(set_no);
    return (blk << shift) | (offset & ((ADDR_W'(1) << shift) - 1));
  endfunction

  task automatic send_access(input logic [ADDR_W-1:0] address, input logic opcode);
    int unsigned gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(99) < 18) gap++;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.address <= address;
    req_ch.opcode  <= opcode;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_access(address, opcode);
  endtask

  // hold off until every outstanding request has been answered
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * CFG_IDX_BSL);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.block_size_log = value[BSL_W-1:0];
  endtask

  // mostly a few hot sets and a handful of tags so that ways fill, hit and get evicted
  task automatic random_access();
    int unsigned       kind, set_no, pick;
    logic [ADDR_W-1:0] tag;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_access($urandom, $urandom_range(1));
    end else begin
      set_no = (kind < 70) ? $urandom_range(3) : $urandom_range(SETS - 1);
      pick   = $urandom_range(5);
      tag    = (pick < 3) ? ADDR_W'(pick) : ~ADDR_W'(pick);
      if (kind >= 90) tag = $urandom_range(15);
      send_access(block_address(sb.offset_bits(), set_no, tag, $urandom), $urandom_range(1));
    end
  endtask

  initial begin
    logic [PDATA_W-1:0] settings [10];
    settings = '{32'd12, 32'd2, 32'd1, 32'd13, 32'd7, 32'hA5A5_A5A3, 32'd0, 32'd15, 32'd4,
                 32'd6};
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.address <= '0;
    req_ch.opcode  <= OP_READ;
    steady         = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset block size: extremes of the address, fill and evict in one set
    send_access(32'h0000_0000, OP_READ);
    send_access(32'h0000_003F, OP_READ);
    send_access(32'hFFFF_FFFF, OP_WRITE);
    send_access(32'hFFFF_FFC0, OP_WRITE);
    for (int t = 1; t <= 4; t++)
      send_access(block_address(BSL_RESET, 0, t, 0), (t % 2) ? OP_WRITE : OP_READ);
    send_access(block_address(BSL_RESET, 0, 2, 5), OP_READ);
    send_access(block_address(BSL_RESET, 0, 0, 0), OP_WRITE);
    send_access(32'h8000_0000, OP_READ);
    send_access(32'h7FFF_FFFF, OP_WRITE);

    // block size below range clamps to the smallest
    drain();
    write_block_size(32'd0);
    send_access(32'hFFFF_FFFF, OP_READ);
    send_access(32'h0000_0003, OP_WRITE);
    send_access(32'hFFFF_FFFC, OP_READ);
    send_access(32'h0000_0004, OP_WRITE);

    // block size above range clamps to the largest
    drain();
    write_block_size(32'd15);
    send_access(32'hFFFF_FFFF, OP_WRITE);
    send_access(32'h0000_0FFF, OP_READ);
    send_access(32'h0000_1000, OP_READ);
    send_access(32'hFFFF_F000, OP_WRITE);
    send_access(32'h0000_0000, OP_WRITE);

    for (int p = 0; p < 10; p++) begin
      drain();
      write_block_size(settings[p]);
      steady = (p == 3);
      for (int n = 0; n < 170; n++) begin
        if (p == 1 && n == 85) drain();
        random_access();
      end
      steady = 1'b0;
    end

    drain();
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/salc_pkg.sv
design/salc_if.sv
design/salc_ram.sv
design/salc_ctrl.sv
design/salc_dp.sv
design/set_assoc_lru_cache_model.sv
design/salc_checker.sv
test/testbench.sv
